// ===== rtl/core/pss_pkg.sv =====
// Shared widths, codes and the ring write-port type for the plucked-string voice.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pss_pkg;

    // Ring geometry
    localparam int unsigned MAX_LENGTH = 2048;
    localparam int unsigned ADDR_W     = $clog2(MAX_LENGTH);
    localparam int unsigned LEN_W      = ADDR_W + 1;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned DECAY_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Tick arithmetic: 17-bit sum times unsigned Q0.16 decay, divide by 2^17
    localparam int unsigned SUM_W      = SAMPLE_W + 1;
    localparam int unsigned PROD_W     = 2 * SUM_W;
    localparam int unsigned FRAC_SHIFT = 17;

    // Noise generator
    localparam logic [SAMPLE_W-1:0] LFSR_TAPS = 16'hB400;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED    = 2'd2;

    // Configuration reset values
    localparam logic [LEN_W-1:0]    RST_BUFFER_LENGTH = 12'd100;
    localparam logic [DECAY_W-1:0]  RST_DECAY_FACTOR  = 16'd65274;
    localparam logic [SAMPLE_W-1:0] RST_NOISE_SEED    = 16'd44257;

    // Action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_PLUCK = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // Ring write port
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } ring_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/pss_ring.sv =====
// Sample ring storage: one write port, one registered read port.
// Depends on pss_pkg for widths and the write-port struct.
`default_nettype none

module pss_ring (
    input  wire logic                          clk,
    input  wire pss_pkg::ring_wr_t             wr,
    input  wire logic                          rd_en,
    input  wire logic [pss_pkg::ADDR_W-1:0]    rd_addr,
    output logic      [pss_pkg::SAMPLE_W-1:0]  rd_data
);
    import pss_pkg::*;

    logic [SAMPLE_W-1:0] mem [MAX_LENGTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/plucked_string_synth_unit.sv =====
// Karplus-Strong plucked-string voice: sequencer, tick datapath and noise LFSR.
// Depends on pss_pkg and instantiates pss_ring for the sample ring.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------
//  input     | in_valid / in_stall | action, load_value
//  output    | out_valid/out_stall | current_sample, step_count
//  config    | cfg_we              | cfg_index, cfg_wdata
//
// One item at a time. A tick makes two ring reads through the single read
// port, then a registered multiply; load and no-op pass straight to the
// result; a pluck writes the whole ring, one ring write per cycle
// (buffer_length clamped to 2..2048).
// After reset a clearing pass zeroes all 2048 ring entries with in_stall
// high. A result held by out_stall keeps the next item waiting in its
// result state, with in_stall high, until the output register frees up; the
// ring write of a tick or load happens together with its result.
`default_nettype none

module plucked_string_synth_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [pss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      action,
    input  wire logic signed [pss_pkg::SAMPLE_W-1:0] load_value,
    // result items
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [pss_pkg::SAMPLE_W-1:0]  current_sample,
    output logic [pss_pkg::COUNT_W-1:0]          step_count
);
    import pss_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RDB   = 6'b000100,
        S_MUL   = 6'b001000,
        S_PLUCK = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [LEN_W-1:0]    len_cfg_reg;
    logic [DECAY_W-1:0]  decay_reg;

    // control state
    logic [ADDR_W-1:0]   front_reg, front_next;
    logic [COUNT_W-1:0]  time_reg, time_next;
    logic [SAMPLE_W-1:0] noise_reg, noise_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;

    // item payload and datapath
    logic [1:0]                 action_reg;
    logic [SAMPLE_W-1:0]        load_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0]        first_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [COUNT_W-1:0]         count_reg;

    // ring port
    ring_wr_t            ring_wr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    logic [LEN_W-1:0]    ring_len;
    logic [ADDR_W-1:0]   last_idx;
    logic [ADDR_W-1:0]   front_inc;
    logic                accept;
    logic                fin_go;
    logic [SAMPLE_W-1:0] lfsr_step;
    logic [SAMPLE_W-1:0] seed_eff;
    logic signed [SUM_W-1:0]  pair_sum;
    logic signed [PROD_W:0]   biased;
    logic [SAMPLE_W-1:0]      tick_value;

    pss_ring u_ring (
        .clk     (clk),
        .wr      (ring_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // length clamp and ring index wrap
    always_comb
    begin
        priority if (len_cfg_reg < LEN_W'(2))
        begin
            ring_len = LEN_W'(2);
        end
        else if (len_cfg_reg > LEN_W'(MAX_LENGTH))
        begin
            ring_len = LEN_W'(MAX_LENGTH);
        end
        else
        begin
            ring_len = len_cfg_reg;
        end
    end

    assign last_idx  = ADDR_W'(ring_len - LEN_W'(1));
    assign front_inc = (front_reg == last_idx) ? '0 : front_reg + ADDR_W'(1);

    // noise LFSR, Galois form
    assign lfsr_step = noise_reg[0] ? ((noise_reg >> 1) ^ LFSR_TAPS) : (noise_reg >> 1);
    assign seed_eff  = (cfg_wdata == '0) ? SAMPLE_W'(1) : cfg_wdata;

    // tick arithmetic: ceil(decay * (a + b) / 2^17)
    assign pair_sum   = SUM_W'(a_reg) + SUM_W'($signed(rd_data));
    assign biased     = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'((1 << FRAC_SHIFT) - 1);
    assign tick_value = biased[FRAC_SHIFT + SAMPLE_W - 1:FRAC_SHIFT];

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign fin_go   = !out_valid_reg || !out_stall;

    // ring read address
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = front_reg;
        if (accept && action != ACT_PLUCK)
        begin
            rd_en   = 1'b1;
            rd_addr = (action == ACT_LOAD) ? front_inc : front_reg;
        end
        else if (state_reg == S_RDB)
        begin
            rd_en   = 1'b1;
            rd_addr = front_inc;
        end
    end

    // sequencer and ring writes
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        time_next      = time_reg;
        noise_next     = noise_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        ring_wr        = '{en: 1'b0, addr: front_reg, data: tick_value};

        unique case (state_reg)
            S_CLEAR:
            begin
                ring_wr = '{en: 1'b1, addr: idx_reg, data: '0};
                idx_next = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(MAX_LENGTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    unique case (action)
                        ACT_TICK:  state_next = S_RDB;
                        ACT_PLUCK: state_next = S_PLUCK;
                        ACT_LOAD:  state_next = S_FIN;
                        ACT_NOP:   state_next = S_FIN;
                        default:   state_next = S_FIN;
                    endcase
                end
            end
            S_RDB:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_FIN;
            end
            S_PLUCK:
            begin
                ring_wr    = '{en: 1'b1, addr: idx_reg, data: lfsr_step};
                noise_next = lfsr_step;
                idx_next   = idx_reg + ADDR_W'(1);
                if (idx_reg == last_idx)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    unique case (action_reg)
                        ACT_TICK:
                        begin
                            ring_wr    = '{en: 1'b1, addr: front_reg, data: tick_value};
                            front_next = front_inc;
                            time_next  = time_reg + COUNT_W'(1);
                        end
                        ACT_PLUCK:
                        begin
                            front_next = '0;
                            time_next  = time_reg + COUNT_W'(1);
                        end
                        ACT_LOAD:
                        begin
                            ring_wr    = '{en: 1'b1, addr: front_reg, data: load_reg};
                            front_next = front_inc;
                        end
                        ACT_NOP:
                        begin
                            front_next = front_reg;
                        end
                        default:
                        begin
                            front_next = front_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration side effects
        if (cfg_we && cfg_index == CFG_BUFFER_LENGTH)
        begin
            front_next = '0;
        end
        if (cfg_we && cfg_index == CFG_NOISE_SEED)
        begin
            noise_next = seed_eff;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            front_reg     <= '0;
            time_reg      <= '0;
            noise_reg     <= RST_NOISE_SEED;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            len_cfg_reg   <= RST_BUFFER_LENGTH;
            decay_reg     <= RST_DECAY_FACTOR;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            time_reg      <= time_next;
            noise_reg     <= noise_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BUFFER_LENGTH: len_cfg_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_DECAY_FACTOR:  decay_reg   <= cfg_wdata;
                    default:
                    begin
                        // the seed goes straight into the noise LFSR
                    end
                endcase
            end
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            load_reg   <= load_value;
        end
        if (state_reg == S_RDB)
        begin
            a_reg <= $signed(rd_data);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= $signed({{(PROD_W - DECAY_W){1'b0}}, decay_reg})
                        * PROD_W'(pair_sum);
        end
        if (state_reg == S_PLUCK && idx_reg == '0)
        begin
            first_reg <= lfsr_step;
        end
        if (state_reg == S_FIN && fin_go)
        begin
            sample_reg <= (action_reg == ACT_PLUCK) ? first_reg : rd_data;
            count_reg  <= time_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign current_sample = $signed(sample_reg);
    assign step_count     = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pss_checker.sv =====
// Port-level checks for plucked_string_synth_unit, attached by bind.
// Depends on pss_pkg for widths; sees only the top-level ports.
`default_nettype none

module pss_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic signed [pss_pkg::SAMPLE_W-1:0] current_sample,
    input  wire logic [pss_pkg::COUNT_W-1:0]     step_count
);
    import pss_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(current_sample)
                                   && $stable(step_count))
        else $error("result changed while stalled");

    // one item at a time: after an accepted item the input stalls
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted back to back");

    // a new result only appears while the input side was stalled
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without item in flight");

    // step count of consecutive delivered results advances by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid || $stable(step_count)
            || (step_count == $past(step_count) + COUNT_W'(1)))
        else $error("step count jumped");

endmodule

bind plucked_string_synth_unit pss_checker u_pss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .current_sample (current_sample),
    .step_count     (step_count)
);

`default_nettype wire

// ===== tb/tb_plucked_string_synth_unit.sv =====
// Self-checking testbench for plucked_string_synth_unit: a directed table, then random phases.
// Depends on pss_pkg and the block's RTL; predicts every result in-line and checks each in order.
module tb_plucked_string_synth_unit;
    import pss_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned RANDOM_ITEMS  = 1125;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned DIR_ROWS      = 36;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [COUNT_W-1:0]         count;
    } voice_out_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // code is the action for an item row, the register index for a write row
    typedef struct packed {
        row_kind_t           kind;
        logic [1:0]          code;
        logic [15:0]         data;
        logic                typed;
        logic [SAMPLE_W-1:0] exp_sample;
        logic [COUNT_W-1:0]  exp_count;
    } dir_row_t;

    // Directed table: reset state, the ring length floor, zero seed, full-scale
    // sums, rounding up of tiny products, zero decay, lengths out of range
    // (low, high, upper data bits set), longest pluck and the no-op action.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, ACT_NOP,           16'h0000, 1'b1, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b1, 16'h0000, 32'd1},
        '{ROW_ITEM, ACT_LOAD,          16'h8000, 1'b1, 16'h0000, 32'd1},
        '{ROW_CFG,  CFG_BUFFER_LENGTH, 16'h0002, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_NOP,           16'hFFFF, 1'b1, 16'h0000, 32'd1},
        '{ROW_CFG,  CFG_NOISE_SEED,    16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_PLUCK,         16'h0000, 1'b1, 16'hB400, 32'd2},
        '{ROW_ITEM, ACT_LOAD,          16'h7FFF, 1'b1, 16'h5A00, 32'd2},
        '{ROW_ITEM, ACT_LOAD,          16'h7FFF, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_DECAY_FACTOR,  16'hFFFF, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_LOAD,          16'h8000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_LOAD,          16'h8000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_DECAY_FACTOR,  16'h0001, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_LOAD,          16'h0001, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_LOAD,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_LOAD,          16'hFFFF, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_LOAD,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_DECAY_FACTOR,  16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_BUFFER_LENGTH, 16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_BUFFER_LENGTH, 16'h0FFF, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_PLUCK,         16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_NOISE_SEED,    16'hFFFF, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_BUFFER_LENGTH, 16'hF800, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_PLUCK,         16'h0000, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_BUFFER_LENGTH, 16'h0001, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_NOP,           16'hAAAA, 1'b0, 16'h0000, 32'd0},
        '{ROW_CFG,  CFG_DECAY_FACTOR,  16'hFEFA, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_LOAD,          16'h1234, 1'b0, 16'h0000, 32'd0},
        '{ROW_ITEM, ACT_TICK,          16'h0000, 1'b0, 16'h0000, 32'd0}
    };

    // DUT ports
    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata  = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic [1:0]                 action     = ACT_NOP;
    logic signed [SAMPLE_W-1:0] load_value = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0] current_sample;
    logic [COUNT_W-1:0]         step_count;

    // String state as predicted
    logic [SAMPLE_W-1:0] ring_copy [MAX_LENGTH];
    int unsigned         head_pos;
    logic [COUNT_W-1:0]  step_total;
    logic [SAMPLE_W-1:0] noise_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [DECAY_W-1:0]  decay_reg;

    voice_out_t  pending_samples [$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned writes_done    = 0;
    int unsigned act_seen [4]   = '{0, 0, 0, 0};
    int unsigned cycle_count    = 0;
    bit          no_idle        = 1'b0;
    bit          long_hold_req  = 1'b0;

    plucked_string_synth_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .load_value     (load_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_sample (current_sample),
        .step_count     (step_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Ring length actually in use, clamped to 2..MAX_LENGTH
    function automatic int unsigned ring_span();
        if (len_reg < 2)
            return 2;
        if (len_reg > MAX_LENGTH)
            return MAX_LENGTH;
        return 32'(len_reg);
    endfunction

    // Advance the predicted string by one item and return what it reports
    function automatic voice_out_t predict_voice_step(input logic [1:0] act,
                                                      input logic [SAMPLE_W-1:0] value);
        int unsigned span;
        int unsigned f;
        int unsigned k;
        longint      a;
        longint      b;
        longint      prod;
        longint      q;
        voice_out_t  r;
        span = ring_span();
        f    = head_pos % span;
        case (act)
            ACT_TICK:
            begin
                a    = longint'($signed(ring_copy[f]));
                b    = longint'($signed(ring_copy[(f + 1) % span]));
                prod = longint'(decay_reg) * (a + b);
                // ceiling of prod / 2^17
                q    = (prod + (longint'(1) <<< FRAC_SHIFT) - 1) >>> FRAC_SHIFT;
                ring_copy[f] = q[SAMPLE_W-1:0];
                head_pos     = (f + 1) % span;
                step_total++;
            end
            ACT_PLUCK:
            begin
                for (k = 0; k < span; k++)
                begin
                    noise_reg    = (noise_reg >> 1) ^ (noise_reg[0] ? LFSR_TAPS : '0);
                    ring_copy[k] = noise_reg;
                end
                head_pos = 0;
                step_total++;
            end
            ACT_LOAD:
            begin
                ring_copy[f] = value;
                head_pos     = (f + 1) % span;
            end
            default:
            begin
            end
        endcase
        r.sample = ring_copy[head_pos % span];
        r.count  = step_total;
        return r;
    endfunction

    // Offer one item after a random gap; record its expected result once taken
    task automatic send_item(input logic [1:0] act, input logic [SAMPLE_W-1:0] value,
                             input bit typed, input voice_out_t typed_out);
        int unsigned gap;
        voice_out_t  predicted;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        load_value <= value;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted = predict_voice_step(act, value);
        pending_samples.push_back(typed ? typed_out : predicted);
        act_seen[act]++;
    endtask

    // Let every outstanding result drain, then give the block time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_BUFFER_LENGTH:
            begin
                len_reg  = data[LEN_W-1:0];
                head_pos = 0;
            end
            CFG_DECAY_FACTOR:
                decay_reg = data;
            CFG_NOISE_SEED:
            begin
                noise_reg = (data == '0) ? 16'd1 : data;
            end
            default:
            begin
            end
        endcase
        writes_done++;
    endtask

    // Output side: random holds, one long hold on request, in-order checking
    initial
    begin : result_checker
        int unsigned hold;
        voice_out_t  want;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
            end
            else
                hold = no_idle ? 0 : $urandom_range(0, 15);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            results_seen++;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected result: sample %0d count %0d", $time,
                         current_sample, step_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (current_sample !== want.sample)
                begin
                    $display("%0t: current_sample expected %0d got %0d", $time,
                             want.sample, current_sample);
                    mismatch_count++;
                end
                if (step_count !== want.count)
                begin
                    $display("%0t: step_count expected %0d got %0d", $time,
                             want.count, step_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned row;
        int unsigned phase;
        int unsigned n;
        int unsigned items;
        int unsigned pick;
        int unsigned span_pick;
        int unsigned random_sent;
        int unsigned r;
        logic [15:0] word;
        logic [1:0]  act;
        bit          big;

        // predicted state after reset
        foreach (ring_copy[i])
            ring_copy[i] = '0;
        head_pos    = 0;
        step_total  = '0;
        len_reg     = RST_BUFFER_LENGTH;
        decay_reg   = RST_DECAY_FACTOR;
        noise_reg   = RST_NOISE_SEED;
        random_sent = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; item rows wait out the clearing pass via in_stall
        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (dir_rows[row].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(dir_rows[row].code, dir_rows[row].data);
            end
            else
                send_item(dir_rows[row].code, dir_rows[row].data, dir_rows[row].typed,
                          {dir_rows[row].exp_sample, dir_rows[row].exp_count});
        end

        // random phases; registers are rewritten before each (all in the first)
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            pick = $urandom_range(0, 19);
            if (pick < 13)
                span_pick = $urandom_range(2, 40);
            else if (pick < 16)
                span_pick = $urandom_range(41, 300);
            else if (pick < 18)
                span_pick = $urandom_range(1000, 2048);
            else if (pick == 18)
                span_pick = $urandom_range(0, 1);
            else
                span_pick = $urandom_range(2049, 4095);
            if (phase == 0 || $urandom_range(0, 1) == 1)
            begin
                word       = 16'($urandom);
                word[11:0] = 12'(span_pick);
                write_reg(CFG_BUFFER_LENGTH, word);
            end
            if (phase == 0 || $urandom_range(0, 1) == 1)
            begin
                r    = $urandom_range(0, 5);
                word = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
                write_reg(CFG_DECAY_FACTOR, word);
            end
            if (phase == 0 || $urandom_range(0, 1) == 1)
            begin
                r    = $urandom_range(0, 5);
                word = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
                write_reg(CFG_NOISE_SEED, word);
            end
            big     = ring_span() > 300;
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 2)
                long_hold_req = 1'b1;
            items = $urandom_range(40, 120);
            for (n = 0; n < items && random_sent < RANDOM_ITEMS; n++)
            begin
                // plucks are rare on long rings, since a pluck writes every sample
                r = $urandom_range(0, 99);
                if (r < 50)
                    act = ACT_TICK;
                else if (r < 78)
                    act = ACT_LOAD;
                else if (r < (big ? 98 : 88))
                    act = ACT_NOP;
                else
                    act = ACT_PLUCK;
                word = 16'($urandom);
                send_item(act, word, 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        wait_idle();
        $display("items: %0d ticks, %0d plucks, %0d loads, %0d no-ops; %0d results checked",
                 act_seen[ACT_TICK], act_seen[ACT_PLUCK], act_seen[ACT_LOAD],
                 act_seen[ACT_NOP], results_seen);
        $display("%0d register writes, %0d random phases, one %0d-cycle output hold",
                 writes_done, phase, LONG_HOLD);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
